### sv/pcsd_pkg.sv
// Shared constants and helpers for the permutation-cycle string decoder.
// Depends on nothing; used by permutation_cycle_string_decoder.
`default_nettype none

package pcsd_pkg;

    // Alphabet and position widths.
    localparam int ALPHABET_SIZE = 94;
    localparam int POS_W         = $clog2(ALPHABET_SIZE);
    localparam int J_W           = $clog2(ALPHABET_SIZE);
    localparam int N_W           = $clog2(ALPHABET_SIZE + 1);

    // Character codes.
    localparam logic [7:0] CODE_LO     = 8'd32;
    localparam logic [7:0] CODE_HI     = 8'd127;
    localparam logic [6:0] CHAR_OFFSET = 7'd33;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_COMMERCIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FREE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFICE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_PLAIN      = 2'd3;

    // Reciprocal of three: floor(m / 3) = (m * RECIP3) >> 33 for any 32-bit m.
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    // Reciprocal of the alphabet size for a 32-bit dividend.
    localparam int          DIV_SHIFT      = 32 + POS_W;
    localparam logic [63:0] DIV_MAGIC_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(ALPHABET_SIZE) - 64'd1) / 64'(ALPHABET_SIZE);
    localparam logic [32:0] DIV_MAGIC      = DIV_MAGIC_FULL[32:0];
    localparam int          MOD_PW         = 65;

    // Last generator phase of a step.
    localparam logic [2:0] GEN_LAST_PHASE = 3'd4;

    // Magnitude of a two's complement word; the most negative value gives 2^31.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

`default_nettype wire

### sv/permutation_cycle_string_decoder.sv
// A bad code goes straight to the output state; a valid code without a rebuild walks
// (code - 32) steps, one permutation memory read per step.
// A rebuild adds ALPHABET_SIZE + 1 generator steps, a linear probe past occupied slots
// for each link, and a closing step that links the last slot back to the first.
// One item is in flight at a time; the next beat is taken while a result waits.
// Reset clears the seeds, generator words, positions and the built flag; the table is rebuilt first.
`default_nettype none

module permutation_cycle_string_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [pcsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      code_char,
    input  wire logic                            first_of_string,
    input  wire logic                            commercial_mode,
    input  wire logic                            office_mode,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [6:0]                           plain_char,
    output logic                                 bad_code
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_GEN     = 3'd1;
    localparam logic [2:0] ST_PROBE   = 3'd2;
    localparam logic [2:0] ST_LINK    = 3'd3;
    localparam logic [2:0] ST_WALK_RD = 3'd4;
    localparam logic [2:0] ST_WALK    = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    localparam logic [1:0] GP_START = 2'd0;
    localparam logic [1:0] GP_FIRST = 2'd1;
    localparam logic [1:0] GP_K     = 2'd2;

    localparam int POS_W = pcsd_pkg::POS_W;
    localparam int J_W   = pcsd_pkg::J_W;
    localparam int N_W   = pcsd_pkg::N_W;
    localparam int D     = pcsd_pkg::ALPHABET_SIZE;

    // Configuration.
    logic [31:0] seed_commercial_reg;
    logic [31:0] seed_free_reg;
    logic [31:0] seed_office_reg;
    logic [31:0] seed_plain_reg;

    // Control and architectural state.
    logic [2:0]       state_reg;
    logic [1:0]       purpose_reg;
    logic [2:0]       phase_reg;
    logic [31:0]      gen_a_reg;
    logic [31:0]      gen_b_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] first_reg;
    logic [POS_W-1:0] cur_reg;
    logic [POS_W-1:0] k_reg;
    logic [POS_W-1:0] pos_reg;
    logic [J_W-1:0]   j_reg;
    logic [N_W-1:0]   n_reg;
    logic [6:0]       steps_reg;
    logic             built_reg;
    logic             res_bad_reg;
    logic [D-1:0]     taken_reg;

    // Output register.
    logic       out_valid_reg;
    logic [6:0] plain_reg;
    logic       bad_reg;

    // Generator datapath registers.
    logic [30:0] q3_reg;
    logic        neg_reg;
    logic [31:0] prod_reg;
    logic [31:0] xm_reg;
    logic [31:0] qm_reg;

    // Permutation memory.
    logic [POS_W-1:0] perm_mem [0:D-1];
    logic [POS_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [POS_W-1:0] mem_wdata;
    logic             mem_re;
    logic [POS_W-1:0] mem_raddr;

    // Generator combinational terms.
    logic [31:0]        sum_s;
    logic [31:0]        sum_mag;
    logic [63:0]        div3_prod;
    logic [31:0]        t_mag;
    logic [31:0]        t_val;
    logic [31:0]        five_t;
    logic [31:0]        gen_a_next;
    logic [31:0]        gen_b_next;
    logic [31:0]        ab_low;
    logic [31:0]        xm_next;
    logic [pcsd_pkg::MOD_PW-1:0] mod_prod;
    logic [31:0]        rem_full;
    logic [POS_W-1:0]   gen_result;

    // Control combinational terms.
    logic             in_accept;
    logic             code_is_bad;
    logic             out_free;
    logic             probe_hit;
    logic [POS_W-1:0] k_next;
    logic             more_links;
    logic [6:0]       plain_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign plain_char = plain_reg;
    assign bad_code   = bad_reg;
    assign out_free   = !out_valid_reg || out_ready;

    assign code_is_bad = (code_char < pcsd_pkg::CODE_LO) || (code_char > pcsd_pkg::CODE_HI);

    // Generator step, spread over five phases with a register after each multiply.
    assign sum_s      = gen_a_reg + {gen_b_reg[30:0], 1'b0};
    assign sum_mag    = pcsd_pkg::mag32(sum_s);
    assign div3_prod  = 64'(sum_mag) * 64'(pcsd_pkg::RECIP3);
    assign t_mag      = {1'b0, q3_reg};
    assign t_val      = neg_reg ? (~t_mag + 32'd1) : t_mag;
    assign five_t     = {t_val[29:0], 2'b00} + t_val;
    assign gen_a_next = gen_a_reg ^ (five_t - gen_b_reg);
    assign gen_b_next = {t_val[30:0], 1'b0} - gen_a_next;
    assign ab_low     = gen_a_reg * gen_b_reg;
    assign xm_next    = pcsd_pkg::mag32(prod_reg);
    assign mod_prod   = pcsd_pkg::MOD_PW'(xm_next) * pcsd_pkg::MOD_PW'(pcsd_pkg::DIV_MAGIC);
    assign rem_full   = xm_reg - 32'(qm_reg * 32'(D));
    assign gen_result = rem_full[POS_W-1:0];

    // Linear probe: skip slots already linked and the current slot itself.
    assign probe_hit  = (n_reg < N_W'(D)) && (taken_reg[k_reg] || (k_reg == cur_reg));
    assign k_next     = (k_reg == POS_W'(D - 1)) ? '0 : k_reg + POS_W'(1);
    assign more_links = ((J_W + 2)'(j_reg) + (J_W + 2)'(2)) < (J_W + 2)'(D);

    assign plain_next = res_bad_reg ? 7'd0 : 7'(pos_reg) + pcsd_pkg::CHAR_OFFSET;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = k_reg;
        mem_re    = 1'b0;
        mem_raddr = pos_reg;
        unique case (state_reg)
            ST_PROBE:
            begin
                mem_we = !probe_hit;
            end
            ST_LINK:
            begin
                mem_we    = 1'b1;
                mem_wdata = first_reg;
            end
            ST_WALK_RD:
            begin
                mem_re = (steps_reg != 7'd0);
            end
            ST_WALK:
            begin
                mem_re    = (steps_reg != 7'd1);
                mem_raddr = rd_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= perm_mem[mem_raddr];
        end
    end

    // Generator pipeline registers load every cycle; the phase counter picks the useful one.
    always_ff @(posedge clk)
    begin
        q3_reg   <= div3_prod[63:pcsd_pkg::RECIP3_SHIFT];
        neg_reg  <= sum_s[31];
        prod_reg <= ab_low;
        xm_reg   <= xm_next;
        qm_reg   <= 32'(mod_prod >> pcsd_pkg::DIV_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_commercial_reg <= '0;
            seed_free_reg       <= '0;
            seed_office_reg     <= '0;
            seed_plain_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pcsd_pkg::CFG_SEED_COMMERCIAL: seed_commercial_reg <= cfg_data;
                pcsd_pkg::CFG_SEED_FREE:       seed_free_reg       <= cfg_data;
                pcsd_pkg::CFG_SEED_OFFICE:     seed_office_reg     <= cfg_data;
                pcsd_pkg::CFG_SEED_PLAIN:      seed_plain_reg      <= cfg_data;
                default:                       seed_plain_reg      <= seed_plain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            purpose_reg   <= GP_START;
            phase_reg     <= '0;
            gen_a_reg     <= '0;
            gen_b_reg     <= '0;
            start_reg     <= '0;
            first_reg     <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            steps_reg     <= '0;
            built_reg     <= 1'b0;
            res_bad_reg   <= 1'b0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
            plain_reg     <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            // In the output state a departing result is replaced by the new one below.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        steps_reg   <= 7'(code_char - pcsd_pkg::CODE_LO);
                        res_bad_reg <= code_is_bad;
                        if (code_is_bad)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (first_of_string || !built_reg)
                        begin
                            gen_a_reg   <= commercial_mode ? seed_commercial_reg : seed_free_reg;
                            gen_b_reg   <= office_mode ? seed_office_reg : seed_plain_reg;
                            taken_reg   <= '0;
                            phase_reg   <= '0;
                            purpose_reg <= GP_START;
                            state_reg   <= ST_GEN;
                        end
                        else
                        begin
                            state_reg <= ST_WALK_RD;
                        end
                    end
                end

                ST_GEN:
                begin
                    if (phase_reg == pcsd_pkg::GEN_LAST_PHASE)
                    begin
                        phase_reg <= '0;
                        unique case (purpose_reg)
                            GP_START:
                            begin
                                start_reg   <= gen_result;
                                purpose_reg <= GP_FIRST;
                            end
                            GP_FIRST:
                            begin
                                first_reg   <= gen_result;
                                cur_reg     <= gen_result;
                                j_reg       <= '0;
                                purpose_reg <= GP_K;
                            end
                            default:
                            begin
                                k_reg     <= gen_result;
                                n_reg     <= '0;
                                state_reg <= ST_PROBE;
                            end
                        endcase
                    end
                    else
                    begin
                        // The new generator words are taken at the end of the second phase.
                        if (phase_reg == 3'd1)
                        begin
                            gen_a_reg <= gen_a_next;
                            gen_b_reg <= gen_b_next;
                        end
                        phase_reg <= phase_reg + 3'd1;
                    end
                end

                ST_PROBE:
                begin
                    if (probe_hit)
                    begin
                        k_reg <= k_next;
                        n_reg <= n_reg + N_W'(1);
                    end
                    else
                    begin
                        taken_reg[cur_reg] <= 1'b1;
                        cur_reg            <= k_reg;
                        j_reg              <= j_reg + J_W'(1);
                        if (more_links)
                        begin
                            phase_reg <= '0;
                            state_reg <= ST_GEN;
                        end
                        else
                        begin
                            state_reg <= ST_LINK;
                        end
                    end
                end

                ST_LINK:
                begin
                    // The last slot closes the cycle back to the first one.
                    taken_reg[cur_reg] <= 1'b1;
                    built_reg          <= 1'b1;
                    pos_reg            <= start_reg;
                    state_reg          <= ST_WALK_RD;
                end

                ST_WALK_RD:
                begin
                    if (steps_reg == 7'd0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_WALK;
                    end
                end

                ST_WALK:
                begin
                    pos_reg   <= rd_data_reg;
                    steps_reg <= steps_reg - 7'd1;
                    if (steps_reg == 7'd1)
                    begin
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        plain_reg     <= plain_next;
                        bad_reg       <= res_bad_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sim/tb_permutation_cycle_string_decoder.sv
// Self-checking testbench for permutation_cycle_string_decoder: directed and random text
// through the valid/ready channels, checked against a predictor of the cycle decoder.
// Depends on pcsd_pkg and the decoder RTL only.

module tb_permutation_cycle_string_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 20;

    localparam int                            CFG_IDX_W           = pcsd_pkg::CFG_IDX_W;
    localparam int                            ALPHABET_SIZE       = pcsd_pkg::ALPHABET_SIZE;
    localparam logic [7:0]                    CODE_LO             = pcsd_pkg::CODE_LO;
    localparam logic [7:0]                    CODE_HI             = pcsd_pkg::CODE_HI;
    localparam logic [6:0]                    CHAR_OFFSET         = pcsd_pkg::CHAR_OFFSET;
    localparam logic [CFG_IDX_W-1:0]          CFG_SEED_COMMERCIAL = pcsd_pkg::CFG_SEED_COMMERCIAL;
    localparam logic [CFG_IDX_W-1:0]          CFG_SEED_FREE       = pcsd_pkg::CFG_SEED_FREE;
    localparam logic [CFG_IDX_W-1:0]          CFG_SEED_OFFICE     = pcsd_pkg::CFG_SEED_OFFICE;
    localparam logic [CFG_IDX_W-1:0]          CFG_SEED_PLAIN      = pcsd_pkg::CFG_SEED_PLAIN;

    typedef struct packed {
        logic [6:0] ch;
        logic       bad;
    } decoded_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           code_char;
    logic                 first_of_string;
    logic                 commercial_mode;
    logic                 office_mode;
    logic                 out_valid;
    logic                 out_ready;
    logic [6:0]           plain_char;
    logic                 bad_code;

    // Predictor state: seeds, successor table and the walking position.
    logic [31:0] seed_word [4];
    logic [6:0]  successor [ALPHABET_SIZE];
    bit          slot_used [ALPHABET_SIZE];
    logic [31:0] gen_x;
    logic [31:0] gen_y;
    int unsigned origin_pos;
    int unsigned walk_pos;
    bit          have_table;

    decoded_t    expected_chars [$];
    int          idle_pct;
    int          stall_pct;
    int          mismatches;
    int          chars_sent;
    int          results_checked;
    int          rebuilds_seen;
    int          bad_codes_sent;
    int unsigned chars_left;

    permutation_cycle_string_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .code_char       (code_char),
        .first_of_string (first_of_string),
        .commercial_mode (commercial_mode),
        .office_mode     (office_mode),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .plain_char      (plain_char),
        .bad_code        (bad_code)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [31:0] abs_word(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    // One step of the generator; the division truncates towards zero.
    function automatic int unsigned gen_draw();
        logic [31:0] sum;
        logic [31:0] quot;
        logic [31:0] third;
        sum   = gen_x + (gen_y << 1);
        quot  = abs_word(sum) / 32'd3;
        third = sum[31] ? 32'd0 - quot : quot;
        gen_x = gen_x ^ (32'd5 * third - gen_y);
        gen_y = (third << 1) - gen_x;
        return abs_word(gen_y * gen_x) % 32'(ALPHABET_SIZE);
    endfunction

    function automatic void rebuild_cycle(input bit comm_bit, input bit office_bit);
        int unsigned cur;
        int unsigned head;
        int unsigned slot;
        int unsigned probes;
        int unsigned link;
        gen_x = comm_bit ? seed_word[CFG_SEED_COMMERCIAL] : seed_word[CFG_SEED_FREE];
        gen_y = office_bit ? seed_word[CFG_SEED_OFFICE] : seed_word[CFG_SEED_PLAIN];
        origin_pos = gen_draw();
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        head = gen_draw();
        cur  = head;
        for (link = 0; link + 1 < ALPHABET_SIZE; link++)
        begin
            slot   = gen_draw();
            probes = 0;
            // Linear probe past taken slots and the current one, at most once round.
            while (probes < ALPHABET_SIZE && (slot_used[slot] || slot == cur))
            begin
                slot = (slot + 1 >= ALPHABET_SIZE) ? 0 : slot + 1;
                probes++;
            end
            successor[cur] = 7'(slot);
            slot_used[cur] = 1'b1;
            cur = slot;
        end
        successor[cur] = 7'(head);
        slot_used[cur] = 1'b1;
        have_table = 1'b1;
        rebuilds_seen++;
    endfunction

    function automatic decoded_t decode_char(input logic [7:0] code, input bit first_flag,
                                             input bit comm_bit, input bit office_bit);
        decoded_t    res;
        int unsigned pos;
        int unsigned steps;
        if (code < CODE_LO || code > CODE_HI)
        begin
            bad_codes_sent++;
            res.ch  = '0;
            res.bad = 1'b1;
            return res;
        end
        if (first_flag || !have_table)
        begin
            rebuild_cycle(comm_bit, office_bit);
            walk_pos = origin_pos;
        end
        pos = walk_pos;
        for (steps = 32'(code - CODE_LO); steps > 0; steps--)
            pos = (pos < ALPHABET_SIZE) ? 32'(successor[pos]) : 32'd0;
        walk_pos = pos;
        res.ch  = 7'(pos + CHAR_OFFSET);
        res.bad = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("tb: mismatch at %0t ns: %s", $realtime, what);
    endtask

    // Result side: random back-pressure and comparison with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        decoded_t want;
        out_ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("result %0d/%0b with nothing expected",
                                          plain_char, bad_code));
            else
            begin
                want = expected_chars.pop_front();
                results_checked++;
                if (plain_char !== want.ch)
                    report_mismatch($sformatf("plain_char %0d, expected %0d",
                                              plain_char, want.ch));
                if (bad_code !== want.bad)
                    report_mismatch($sformatf("bad_code %0b, expected %0b",
                                              bad_code, want.bad));
            end
        end
    end

    task automatic send_char(input logic [7:0] code, input bit first_flag,
                             input bit comm_bit, input bit office_bit);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        code_char       <= code;
        first_of_string <= first_flag;
        commercial_mode <= comm_bit;
        office_mode     <= office_bit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_chars.push_back(decode_char(code, first_flag, comm_bit, office_bit));
        chars_sent++;
    endtask

    // Holds the sender back until every result is in, plus a short settling margin.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        seed_word[idx] = value;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_seeds(input logic [31:0] commercial, input logic [31:0] free_seed,
                              input logic [31:0] office, input logic [31:0] plain);
        wait_idle();
        write_seed(CFG_SEED_COMMERCIAL, commercial);
        write_seed(CFG_SEED_FREE, free_seed);
        write_seed(CFG_SEED_OFFICE, office);
        write_seed(CFG_SEED_PLAIN, plain);
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return $urandom_range(1) ? 8'($urandom_range(31, 0)) : 8'($urandom_range(255, 128));
        if (roll < 14)
            return CODE_LO;
        if (roll < 19)
            return CODE_HI;
        if (roll < 22)
            return CODE_LO + 8'd1;
        return 8'($urandom_range(127, 32));
    endfunction

    // The first beats run on the reset seeds, so the opening valid one builds the table.
    task automatic test_no_table_yet();
        send_char(8'd0, 1'b1, 1'b1, 1'b0);
        send_char(8'd31, 1'b0, 1'b0, 1'b0);
        send_char(8'd40, 1'b0, 1'b0, 1'b0);
        send_char(CODE_LO, 1'b0, 1'b1, 1'b1);
        send_char(8'd128, 1'b1, 1'b1, 1'b1);
        send_char(CODE_HI, 1'b0, 1'b0, 1'b0);
        send_char(8'd255, 1'b0, 1'b0, 1'b1);
        send_char(CODE_LO + 8'd1, 1'b0, 1'b0, 1'b0);
        wait_idle();
    endtask

    // Extreme seeds under all four mode combinations.
    task automatic test_seed_extremes();
        load_seeds(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        for (int mode = 0; mode < 4; mode++)
        begin
            send_char(CODE_LO, 1'b1, mode[1], mode[0]);
            send_char(CODE_HI, 1'b0, ~mode[1], ~mode[0]);
        end
        send_char(8'd94, 1'b0, 1'b1, 1'b1);
        wait_idle();
    endtask

    // A new string mid-stream must restart from the same start position.
    task automatic test_string_restart();
        send_char(8'd50, 1'b1, 1'b0, 1'b1);
        send_char(8'd60, 1'b0, 1'b1, 1'b0);
        send_char(8'd50, 1'b1, 1'b0, 1'b1);
        send_char(8'd126, 1'b0, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic run_text(input int count);
        logic [7:0] code;
        bit         first_flag;
        for (int i = 0; i < count; i++)
        begin
            code = pick_code();
            if (code < CODE_LO || code > CODE_HI)
                first_flag = 1'($urandom_range(1));
            else if (chars_left == 0)
            begin
                first_flag = 1'b1;
                chars_left = $urandom_range(20, 1);
            end
            else
                first_flag = ($urandom_range(99) < 3);
            if (code >= CODE_LO && code <= CODE_HI)
                chars_left--;
            send_char(code, first_flag, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_text();
        int sender_idle [4];
        int receiver_stall [4];
        sender_idle    = '{0, 61, 0, 10};
        receiver_stall = '{0, 0, 61, 10};
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = sender_idle[phase];
            stall_pct = receiver_stall[phase];
            for (int setting = 0; setting < 2; setting++)
            begin
                load_seeds(pick_seed(), pick_seed(), pick_seed(), pick_seed());
                run_text(241);
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        code_char       <= '0;
        first_of_string <= 1'b0;
        commercial_mode <= 1'b0;
        office_mode     <= 1'b0;
        out_ready       <= 1'b0;
        foreach (seed_word[i])
            seed_word[i] = '0;
        gen_x      = '0;
        gen_y      = '0;
        origin_pos = 0;
        walk_pos   = 0;
        have_table = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        chars_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_table_yet();
        test_seed_extremes();
        test_string_restart();
        test_random_text();

        // A stray result would come within one walk of the table.
        repeat (200) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));
        $display("tb: %0d characters sent (%0d bad codes), %0d results checked",
                 chars_sent, bad_codes_sent, results_checked);
        $display("tb: %0d table rebuilds over the reset seeds, 9 loaded seed settings and %s",
                 rebuilds_seen, "4 idling phases");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: reports failure and stops the run if the stimulus hangs.
    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### permutation_cycle_string_decoder.f
sv/pcsd_pkg.sv
sv/permutation_cycle_string_decoder.sv
sim/tb_permutation_cycle_string_decoder.sv
